// ===== rtl/lcdtb_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdtb_pkg
// Types, codes and helpers shared by the character LCD text buffer modules.
// ----------------------------------------------------------------------------
package lcdtb_pkg;

	localparam int ROW_W  = 2;
	localparam int COL_W  = 5;
	localparam int CHAR_W = 8;
	localparam int NIB_W  = 4;

	localparam int Q_DEPTH = 2;

	// input opcodes
	localparam logic [1:0] OP_SET_CURSOR = 2'd0;
	localparam logic [1:0] OP_PUT_CHAR   = 2'd1;
	localparam logic [1:0] OP_CLEAR      = 2'd2;
	localparam logic [1:0] OP_REFRESH    = 2'd3;

	// command kinds handed from front to back
	localparam logic [1:0] CMD_SET_ADDR = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;
	localparam logic [1:0] CMD_REFRESH  = 2'd3;

	localparam logic [CHAR_W-1:0] SET_ADDR_CMD = 8'h80;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CHAR_W-1:0] char_code;
	} item_t;

	typedef struct packed {
		logic             reg_select;
		logic [NIB_W-1:0] nibble;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CHAR_W-1:0] char_code;
		logic              scroll;
	} cmd_t;

	typedef struct packed {
		logic idle;
		logic out_load;
		logic out_last;
	} back_stat_t;

	function automatic logic [CHAR_W-1:0] addr_cmd(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return SET_ADDR_CMD | ROW_BASE[row] | {{(CHAR_W-COL_W){1'b0}}, col};
	endfunction

endpackage

// ===== rtl/lcdtb_front.sv =====
// ----------------------------------------------------------------------------
// lcdtb_front
// Accepts input items, keeps the write cursor and turns each item into a
// command for the back end; items that do nothing are dropped here.
// ----------------------------------------------------------------------------
module lcdtb_front #(
	parameter int ROWS    = 4,
	parameter int COLUMNS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lcdtb_pkg::item_t item,
	input  logic            q_full,
	output logic            q_push,
	output lcdtb_pkg::cmd_t q_data
);
	import lcdtb_pkg::*;

	localparam logic [ROW_W:0] RowsW = (ROW_W+1)'(ROWS);

	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;

	logic             accept;
	logic             wrap;
	logic [ROW_W:0]   r_next;
	logic             scroll;
	logic [ROW_W-1:0] r_put;
	logic [COL_W-1:0] c_put;
	logic             set_ok;
	logic             ref_ok;
	logic             keep;

	assign full   = q_full;
	assign accept = push && !q_full;

	assign wrap   = cur_col_q >= COL_W'(COLUMNS);
	assign r_next = wrap ? {1'b0, cur_row_q} + (ROW_W+1)'(1) : {1'b0, cur_row_q};
	assign c_put  = wrap ? '0 : cur_col_q;
	assign scroll = r_next >= RowsW;
	assign r_put  = scroll ? ROW_W'(ROWS-1) : r_next[ROW_W-1:0];

	assign ref_ok = {1'b0, item.row} < RowsW;
	assign set_ok = ref_ok && (item.col <= COL_W'(COLUMNS));

	always_comb begin
		q_data.kind      = CMD_CLEAR;
		q_data.row       = item.row;
		q_data.col       = item.col;
		q_data.char_code = item.char_code;
		q_data.scroll    = 1'b0;
		keep             = 1'b1;
		unique case (item.opcode)
			OP_SET_CURSOR: begin
				q_data.kind = CMD_SET_ADDR;
				keep        = set_ok;
			end
			OP_PUT_CHAR: begin
				q_data.kind   = CMD_WRITE;
				q_data.row    = r_put;
				q_data.col    = c_put;
				q_data.scroll = scroll;
			end
			OP_CLEAR: begin
				q_data.kind = CMD_CLEAR;
			end
			OP_REFRESH: begin
				q_data.kind = CMD_REFRESH;
				keep        = ref_ok;
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = accept && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (accept) begin
			if (item.opcode == OP_SET_CURSOR && set_ok) begin
				cur_row_q <= item.row;
				cur_col_q <= item.col;
			end else if (item.opcode == OP_PUT_CHAR) begin
				cur_row_q <= r_put;
				cur_col_q <= c_put + COL_W'(1);
			end
		end
	end

endmodule

// ===== rtl/lcdtb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lcdtb_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module lcdtb_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lcdtb_pkg::cmd_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output lcdtb_pkg::cmd_t rd_data,
	output logic            empty
);
	import lcdtb_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	cmd_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = count_q == (PW+1)'(Q_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/lcdtb_back.sv =====
// ----------------------------------------------------------------------------
// lcdtb_back
// Carries out commands: owns the text store and the scroll offset, and
// sends bytes to the display as nibbles through an output register.
// ----------------------------------------------------------------------------
module lcdtb_back #(
	parameter int ROWS    = 4,
	parameter int COLUMNS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  lcdtb_pkg::cmd_t       q_data,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output lcdtb_pkg::result_t    result,
	output lcdtb_pkg::back_stat_t stat
);
	import lcdtb_pkg::*;

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [ROW_W:0] RowsW = (ROW_W+1)'(ROWS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEND = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]        state_q;
	logic              phase_q;
	logic              out_full_q;
	logic [ROW_W-1:0]  off_q;
	logic [DEPTH-1:0]  valid_q;

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rdata_q;
	logic              rvalid_q;

	logic [CHAR_W-1:0] byte_q;
	logic              rs_q;
	logic              lastbyte_q;
	logic [COL_W-1:0]  col_q;
	logic [AW-1:0]     base_q;
	result_t           out_q;

	logic              dispatch;
	logic              do_write;
	logic              do_clear;
	logic              send_go;
	logic              slot_free;
	logic [ROW_W:0]    row_sum;
	logic [ROW_W-1:0]  prow;
	logic [ROW_W-1:0]  wr_row;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     clr_base;
	logic [AW-1:0]     rd_addr;
	logic [NIB_W-1:0]  nib;

	// logical row to physical row of the store, rotated by the scroll offset
	assign row_sum = {1'b0, q_data.row} + {1'b0, off_q};
	assign prow    = (row_sum >= RowsW) ? ROW_W'(row_sum - RowsW) : row_sum[ROW_W-1:0];

	// after a scroll the new bottom row sits where the old top row was
	assign wr_row   = q_data.scroll ? off_q : prow;
	assign wr_addr  = AW'(wr_row * COLUMNS) + AW'(q_data.col);
	assign clr_base = AW'(off_q * COLUMNS);
	assign rd_addr  = base_q + AW'(col_q);

	assign dispatch  = (state_q == ST_IDLE) && !q_empty;
	assign q_pop     = dispatch;
	assign do_write  = dispatch && (q_data.kind == CMD_WRITE);
	assign do_clear  = dispatch && (q_data.kind == CMD_CLEAR);
	assign slot_free = !out_full_q || pop;
	assign send_go   = (state_q == ST_SEND) && slot_free;
	assign nib       = phase_q ? byte_q[NIB_W-1:0] : byte_q[CHAR_W-1:NIB_W];

	assign empty  = !out_full_q;
	assign result = out_q;

	assign stat.idle     = state_q == ST_IDLE;
	assign stat.out_load = send_go;
	assign stat.out_last = lastbyte_q && phase_q;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= q_data.char_code;
		end
		rdata_q  <= mem[rd_addr];
		rvalid_q <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			off_q   <= '0;
		end else if (do_clear) begin
			valid_q <= '0;
		end else if (do_write) begin
			if (q_data.scroll) begin
				for (int j = 0; j < COLUMNS; j++) begin
					valid_q[clr_base + AW'(j)] <= 1'b0;
				end
				off_q <= (off_q == ROW_W'(ROWS-1)) ? '0 : off_q + ROW_W'(1);
			end
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (dispatch && (q_data.kind == CMD_SET_ADDR ||
						q_data.kind == CMD_REFRESH)) begin
						state_q <= ST_SEND;
						phase_q <= 1'b0;
					end
				end
				ST_SEND: begin
					if (slot_free) begin
						phase_q <= ~phase_q;
						if (phase_q) begin
							state_q <= lastbyte_q ? ST_IDLE : ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
					phase_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (send_go) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch) begin
			byte_q     <= addr_cmd(q_data.row,
				(q_data.kind == CMD_SET_ADDR) ? q_data.col : COL_W'(0));
			rs_q       <= 1'b0;
			lastbyte_q <= q_data.kind == CMD_SET_ADDR;
			col_q      <= '0;
			base_q     <= AW'(prow * COLUMNS);
		end else if (state_q == ST_READ) begin
			// unwritten entries read as space
			byte_q     <= rvalid_q ? rdata_q : SPACE_CHAR;
			rs_q       <= 1'b1;
			lastbyte_q <= col_q == COL_W'(COLUMNS-1);
			col_q      <= col_q + COL_W'(1);
		end
		if (send_go) begin
			out_q.reg_select <= rs_q;
			out_q.nibble     <= nib;
			out_q.last       <= lastbyte_q && phase_q;
		end
	end

endmodule

// ===== rtl/char_lcd_text_buffer_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_text_buffer_scroll_unit
// Text buffer and 4-bit character LCD nibble stream generator.
// ----------------------------------------------------------------------------
// Input channel: an item (opcode, row, col, char_code) transfers when push is
// high and full is low. Result channel: the oldest nibble is on result while
// empty is low and transfers when pop is high.
// Set cursor emits two command nibbles; refresh emits two command nibbles and
// then two data nibbles per column (42 for 20 columns); last marks the final
// nibble of an item. Put character and clear emit nothing.
// The front end decodes one item per cycle, while the queue is not full, into
// a two-entry command queue. The back end takes one command at a time: write
// and clear are done as they are dispatched, and scrolling is done by rotating
// a row offset, so no text is moved. Each byte goes out as two nibble loads;
// in a refresh every byte but the last is followed by a store read that
// fetches the next character; a nibble load waits for a free output register.
// Reset clears the cursor, the scroll offset and the per-entry valid bits, so
// the whole store reads as spaces at once; there is no clearing pass.
// When pop stays low the output register holds, the back end stalls, and the
// queue fills until full goes high.
// ----------------------------------------------------------------------------
module char_lcd_text_buffer_scroll_unit #(
	parameter int ROWS    = 4,
	parameter int COLUMNS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lcdtb_pkg::item_t   item,
	output logic               empty,
	input  logic               pop,
	output lcdtb_pkg::result_t result
);
	import lcdtb_pkg::*;

	logic       q_push;
	logic       q_full;
	cmd_t       q_wdata;
	logic       q_pop;
	logic       q_empty;
	cmd_t       q_rdata;
	back_stat_t stat;

	lcdtb_front #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	lcdtb_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	lcdtb_back #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result),
		.stat   (stat)
	);

`ifndef SYNTHESIS
	// the final nibble of a command returns the sequencer to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.out_load && stat.out_last |=> stat.idle)
		else $error("sequencer not idle after last nibble");

	// commands are taken only while the sequencer is idle
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> stat.idle && !q_empty)
		else $error("command queue read while busy or empty");

	// a nibble is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.out_load |-> empty || pop)
		else $error("output register overwritten");
`endif

endmodule

// ===== tb/lcd_nibble_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_nibble_checker
// Watches both channels of the text buffer, keeps its own copy of the screen
// and cursor, predicts the nibble stream of each input transfer and compares
// every result transfer with the oldest predicted nibble.
// ----------------------------------------------------------------------------
module lcd_nibble_checker #(
	parameter int ROWS    = 4,
	parameter int COLUMNS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  lcdtb_pkg::item_t   item,
	input  logic               empty,
	input  logic               pop,
	input  lcdtb_pkg::result_t result,
	output int                 failures,
	output int                 pending
);

	import lcdtb_pkg::*;

	logic [CHAR_W-1:0] screen [ROWS*COLUMNS];
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cur_col;
	result_t           nibble_stream [$];
	int                fail_count = 0;
	int                stream_left = 0;

	assign failures = fail_count;
	assign pending  = stream_left;

	task automatic blank_screen();
		for (int i = 0; i < ROWS * COLUMNS; i++)
			screen[i] = SPACE_CHAR;
	endtask

	function automatic logic [CHAR_W-1:0] ddram_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return SET_ADDR_CMD | ROW_BASE[r] | {3'b000, c};
	endfunction

	// one byte goes out as high nibble then low nibble
	task automatic queue_byte(input logic rs, input logic [CHAR_W-1:0] b, input logic fin);
		nibble_stream.push_back('{reg_select: rs, nibble: b[7:4], last: 1'b0});
		nibble_stream.push_back('{reg_select: rs, nibble: b[3:0], last: fin});
	endtask

	task automatic predict_nibbles(input item_t it);
		int r;
		int c;
		case (it.opcode)
			OP_SET_CURSOR: begin
				if (int'(it.row) < ROWS && int'(it.col) <= COLUMNS) begin
					cur_row = it.row;
					cur_col = it.col;
					queue_byte(1'b0, ddram_addr(it.row, it.col), 1'b1);
				end
			end
			OP_PUT_CHAR: begin
				r = int'(cur_row);
				c = int'(cur_col);
				if (c >= COLUMNS) begin
					c = 0;
					r++;
				end
				// past the bottom row: move everything up one row
				if (r >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
						screen[i] = screen[i + COLUMNS];
					for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
						screen[i] = SPACE_CHAR;
					r = ROWS - 1;
				end
				screen[r * COLUMNS + c] = it.char_code;
				cur_row = ROW_W'(r);
				cur_col = COL_W'(c + 1);
			end
			OP_CLEAR: begin
				blank_screen();
			end
			default: begin
				if (int'(it.row) < ROWS) begin
					queue_byte(1'b0, ddram_addr(it.row, '0), 1'b0);
					for (int i = 0; i < COLUMNS; i++)
						queue_byte(1'b1, screen[int'(it.row) * COLUMNS + i], i == COLUMNS - 1);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			blank_screen();
			cur_row = '0;
			cur_col = '0;
			nibble_stream.delete();
		end else begin
			// no nibble can leave in the same cycle its item transfers in
			if (push && !full)
				predict_nibbles(item);
			if (pop && !empty) begin
				if (nibble_stream.size() == 0) begin
					$error("result transfer with nothing expected: rs=%0b nibble=%h last=%0b",
						result.reg_select, result.nibble, result.last);
					fail_count++;
				end else begin
					want = nibble_stream.pop_front();
					if (result.reg_select !== want.reg_select) begin
						$error("reg_select: expected %0b, got %0b", want.reg_select,
							result.reg_select);
						fail_count++;
					end
					if (result.nibble !== want.nibble) begin
						$error("nibble: expected %h, got %h", want.nibble, result.nibble);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						fail_count++;
					end
				end
			end
		end
		stream_left = nibble_stream.size();
	end

endmodule

// ===== tb/char_lcd_text_buffer_scroll_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_text_buffer_scroll_unit_test
// Drives set cursor, put character, clear and refresh items into the text
// buffer in random bursts, pops nibbles under a random stall pattern and lets
// the checker compare the stream; prints the verdict.
// ----------------------------------------------------------------------------
module char_lcd_text_buffer_scroll_unit_test;

	import lcdtb_pkg::*;

	localparam int ROWS         = 4;
	localparam int COLUMNS      = 20;
	localparam int RANDOM_ITEMS = 210;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 64;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   in_item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t out_result;
	int      failures;
	int      pending;
	bit      hold_req = 1'b0;
	bit      hold_done = 1'b0;

	char_lcd_text_buffer_scroll_unit #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (in_item),
		.empty  (empty),
		.pop    (pop),
		.result (out_result)
	);

	lcd_nibble_checker #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (in_item),
		.empty    (empty),
		.pop      (pop),
		.result   (out_result),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic item_t make_item(input logic [1:0] op, input int r, input int c,
		input int ch);
		item_t it;
		it.opcode    = op;
		it.row       = ROW_W'(r);
		it.col       = COL_W'(c);
		it.char_code = CHAR_W'(ch);
		return it;
	endfunction

	// mostly well-formed traffic; set cursor now and then lands near the
	// bottom right so that wraps and scrolls happen often
	function automatic item_t random_item();
		item_t it;
		int    pick;
		it = make_item(OP_PUT_CHAR, $urandom_range(0, 3), $urandom_range(0, 31),
			$urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 52) begin
			it.opcode = OP_PUT_CHAR;
		end else if (pick < 72) begin
			it.opcode = OP_SET_CURSOR;
			if ($urandom_range(0, 4) != 0)
				it.col = COL_W'($urandom_range(0, COLUMNS));
			if ($urandom_range(0, 2) == 0) begin
				it.row = ROW_W'(ROWS - 1);
				it.col = COL_W'($urandom_range(COLUMNS - 4, COLUMNS));
			end
		end else if (pick < 96) begin
			it.opcode = OP_REFRESH;
		end else begin
			it.opcode = OP_CLEAR;
		end
		return it;
	endfunction

	// offer one item until it transfers; full is looked at mid-cycle
	task automatic send_item(input item_t it);
		bit taken;
		push    <= 1'b1;
		in_item <= it;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic idle_gap(input int cycles);
		push    <= 1'b0;
		in_item <= make_item(2'($urandom_range(0, 3)), $urandom_range(0, 3),
			$urandom_range(0, 31), $urandom_range(0, 255));
		repeat (cycles) @(posedge clk);
	endtask

	// bursts of random length, random gaps between them
	int burst_left = 0;
	task automatic send_paced(input item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 9) == 0)
				idle_gap($urandom_range(10, 40));
			else if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(1, 6));
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// result side: stretches of steady, random and mostly stalled pop
	initial begin : receiver
		int span;
		int mode;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			repeat (span) begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) != 0);
					default: pop <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		item_t directed [$];
		item_t it;
		int    sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents, end of row, wrap, scroll, ignored positions, clear
		directed.push_back(make_item(OP_REFRESH,    0, 0,  8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 3, 19, 8'h00));
		directed.push_back(make_item(OP_PUT_CHAR,   0, 0,  8'hFF));
		directed.push_back(make_item(OP_PUT_CHAR,   3, 31, 8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 1, 20, 8'hFF));
		directed.push_back(make_item(OP_PUT_CHAR,   0, 0,  8'h41));
		directed.push_back(make_item(OP_SET_CURSOR, 0, 21, 8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 2, 31, 8'hFF));
		directed.push_back(make_item(OP_PUT_CHAR,   0, 0,  8'h5A));
		directed.push_back(make_item(OP_REFRESH,    1, 31, 8'hFF));
		directed.push_back(make_item(OP_REFRESH,    2, 0,  8'h00));
		directed.push_back(make_item(OP_REFRESH,    3, 0,  8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 0, 0,  8'h00));
		directed.push_back(make_item(OP_CLEAR,      3, 31, 8'hFF));
		directed.push_back(make_item(OP_PUT_CHAR,   0, 0,  8'h7E));
		directed.push_back(make_item(OP_REFRESH,    0, 0,  8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 3, 20, 8'h00));
		directed.push_back(make_item(OP_PUT_CHAR,   0, 0,  8'h33));
		directed.push_back(make_item(OP_REFRESH,    2, 0,  8'h00));
		directed.push_back(make_item(OP_REFRESH,    3, 0,  8'h00));
		directed.push_back(make_item(OP_SET_CURSOR, 2, 10, 8'hAA));
		directed.push_back(make_item(OP_SET_CURSOR, 3, 0,  8'h55));
		foreach (directed[i])
			send_paced(directed[i]);

		// sender waits for every nibble before going random
		idle_gap(0);
		wait_drained();

		// receiver goes quiet for a while as the random traffic starts
		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			it = random_item();
			send_paced(it);
			if (!(it.opcode == OP_SET_CURSOR && int'(it.col) > COLUMNS))
				sent++;
		end
		idle_gap(0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
